// ===== sv/reb_pkg.sv =====
// Shared types and constants for the rotary encoder and button qualifier.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none
package reb_pkg;

  // Event codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_A_EDGE = 2'd0,
    OP_BUTTON = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // Reported button state.
  typedef enum logic [1:0] {
    BTN_RELEASED = 2'd0,
    BTN_PRESSED  = 2'd1,
    BTN_LONG     = 2'd2
  } btn_state_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELOAD   = 2'd2;

  localparam int unsigned TimerW = 16;
  localparam int unsigned PosW   = 32;

  localparam logic [TimerW-1:0] DebounceReset = 16'd2000;
  localparam logic [TimerW-1:0] LongReset     = 16'd50000;
  localparam logic [TimerW-1:0] ReloadReset   = 16'd65535;

  // Timer load values held by the configuration registers.
  typedef struct packed {
    logic [TimerW-1:0] debounce_ticks;
    logic [TimerW-1:0] long_press_ticks;
    logic [TimerW-1:0] reload_ticks;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic [1:0] operation;
    logic       b_level;
    logic       button_level;
  } item_t;

  // One result word.
  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic                   turned_clockwise;
    logic                   turned_counterclockwise;
    logic                   press_event;
    logic                   long_press_event;
    logic                   release_event;
    logic [1:0]             button_status;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/reb_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on reb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface reb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       b_level;
  logic       button_level;

  modport source (output valid, output operation, output b_level, output button_level,
                  input ready);
  modport sink (input valid, input operation, input b_level, input button_level,
                output ready);
endinterface

interface reb_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [reb_pkg::PosW-1:0] position;
  logic                            turned_clockwise;
  logic                            turned_counterclockwise;
  logic                            press_event;
  logic                            long_press_event;
  logic                            release_event;
  logic [1:0]                      button_status;

  modport source (output valid, output position, output turned_clockwise,
                  output turned_counterclockwise, output press_event,
                  output long_press_event, output release_event, output button_status,
                  input ready);
  modport sink (input valid, input position, input turned_clockwise,
                input turned_counterclockwise, input press_event,
                input long_press_event, input release_event, input button_status,
                output ready);
endinterface
`default_nettype wire

// ===== sv/rotary_encoder_button_qualifier_top.sv =====
// Top level: input register, event engine, result register, configuration.
// Depends on reb_pkg, reb_if, reb_cfg_regs and reb_engine.
//
//   Port       Dir  Kind          Words
//   in_i       in   valid/ready   operation, b_level, button_level
//   out_o      out  valid/ready   position, turn, press, long, release, status
//   cfg_*_i    in   write only    debounce, long-press, reload timer loads
//
// One word per cycle sustained while results are taken; each word passes
// the input register, then engine logic into the result register.
// The input register takes a word while a result waits, so both sides stall
// independently. Reset clears all state; configuration returns to defaults.
`timescale 1ns / 1ps
`default_nettype none
module rotary_encoder_button_qualifier_top #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  reb_in_if.sink                           in_i,
  reb_out_if.source                        out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [reb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [reb_pkg::TimerW-1:0]  cfg_wdata_i
);

  reb_pkg::cfg_t    cfg;
  reb_pkg::item_t   item_q;
  reb_pkg::result_t result, result_q;
  logic             item_vld_q, out_vld_q;
  logic             advance;

  reb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // The held word moves into the result register when that register is free.
  assign advance    = item_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.operation    <= in_i.operation;
      item_q.b_level      <= in_i.b_level;
      item_q.button_level <= in_i.button_level;
    end
  end

  reb_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_o.valid                   = out_vld_q;
  assign out_o.position                = result_q.position;
  assign out_o.turned_clockwise        = result_q.turned_clockwise;
  assign out_o.turned_counterclockwise = result_q.turned_counterclockwise;
  assign out_o.press_event             = result_q.press_event;
  assign out_o.long_press_event        = result_q.long_press_event;
  assign out_o.release_event           = result_q.release_event;
  assign out_o.button_status           = result_q.button_status;

`ifndef SYNTHESIS
  // A held word is never dropped while the result register is blocked.
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && !advance |=> item_vld_q)
    else $error("input word lost while stalled");

  // Press and release need opposite button levels.
  a_press_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(result_q.press_event && result_q.release_event))
    else $error("press and release in one word");

  // A turn word carries no button event.
  a_turn_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (result_q.turned_clockwise || result_q.turned_counterclockwise) |->
      $onehot({result_q.turned_clockwise, result_q.turned_counterclockwise}) &&
      !(result_q.press_event || result_q.long_press_event || result_q.release_event))
    else $error("turn word mixed with other events");

  // A release event leaves the status at released.
  a_rel_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && result_q.release_event |->
      result_q.button_status == reb_pkg::BTN_RELEASED)
    else $error("release event with wrong status");
`endif

endmodule
`default_nettype wire

// ===== sv/reb_cfg_regs.sv =====
// Configuration registers: debounce, long-press and reload timer loads.
// Depends on reb_pkg for the index codes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none
module reb_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         we_i,
  input  wire logic [reb_pkg::CfgIdxW-1:0]  index_i,
  input  wire logic [reb_pkg::TimerW-1:0]   wdata_i,
  output reb_pkg::cfg_t                     cfg_o
);

  reb_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write index; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        reb_pkg::CFG_DEBOUNCE: cfg_d.debounce_ticks   = wdata_i;
        reb_pkg::CFG_LONG:     cfg_d.long_press_ticks = wdata_i;
        reb_pkg::CFG_RELOAD:   cfg_d.reload_ticks     = wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= reb_pkg::DebounceReset;
      cfg_q.long_press_ticks <= reb_pkg::LongReset;
      cfg_q.reload_ticks     <= reb_pkg::ReloadReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== sv/reb_engine.sv =====
// Event engine: rotation count, debounce checks, timer and reported state.
// Depends on reb_pkg for item, result and configuration types.
`timescale 1ns / 1ps
`default_nettype none
module reb_engine #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire reb_pkg::item_t  item_i,
  input  wire reb_pkg::cfg_t   cfg_i,
  output reb_pkg::result_t     result_o
);

  logic [COUNT_WIDTH-1:0]     count_q, count_d;
  logic                       rotated_q, rotated_d;
  logic                       press_pend_q, press_pend_d;
  logic                       rel_pend_q, rel_pend_d;
  logic                       long_pend_q, long_pend_d;
  logic [reb_pkg::TimerW-1:0] remain_q, remain_d;
  logic                       running_q, running_d;
  reb_pkg::btn_state_e        status_q, status_d;
  logic cw, ccw, pr, lp, rel;

  // Next state for one word, resolved in the same order as the checks fire.
  always_comb begin
    count_d      = count_q;
    rotated_d    = rotated_q;
    press_pend_d = press_pend_q;
    rel_pend_d   = rel_pend_q;
    long_pend_d  = long_pend_q;
    remain_d     = remain_q;
    running_d    = running_q;
    status_d     = status_q;
    cw  = 1'b0;
    ccw = 1'b0;
    pr  = 1'b0;
    lp  = 1'b0;
    rel = 1'b0;
    case (item_i.operation)
      reb_pkg::OP_A_EDGE: begin
        rotated_d = 1'b1;
        if (!item_i.b_level) begin
          count_d = count_q + COUNT_WIDTH'(1);
          cw      = 1'b1;
        end else begin
          count_d = count_q - COUNT_WIDTH'(1);
          ccw     = 1'b1;
        end
      end
      reb_pkg::OP_BUTTON: begin
        if (!item_i.button_level) press_pend_d = 1'b1;
        else                      rel_pend_d   = 1'b1;
        remain_d  = cfg_i.debounce_ticks;
        running_d = 1'b1;
      end
      reb_pkg::OP_TICK: begin
        if (running_q) begin
          if (remain_q != '0) begin
            remain_d = remain_q - reb_pkg::TimerW'(1);
          end else begin
            remain_d = cfg_i.reload_ticks;
            // Long-press check.
            if (long_pend_q) begin
              long_pend_d = 1'b0;
              if (!item_i.button_level) begin
                status_d = reb_pkg::BTN_LONG;
                lp       = 1'b1;
              end
            end
            // Press check: a confirmed press arms the long-press timing.
            if (press_pend_q) begin
              press_pend_d = 1'b0;
              if (!item_i.button_level) begin
                status_d    = reb_pkg::BTN_PRESSED;
                rotated_d   = 1'b0;
                pr          = 1'b1;
                long_pend_d = 1'b1;
                remain_d    = cfg_i.long_press_ticks;
              end
            end
            // Release check: only counts when no rotation followed the press.
            if (rel_pend_q) begin
              rel_pend_d = 1'b0;
              if (item_i.button_level && !rotated_d) begin
                status_d  = reb_pkg::BTN_RELEASED;
                rel       = 1'b1;
                running_d = 1'b0;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      rotated_q    <= 1'b0;
      press_pend_q <= 1'b0;
      rel_pend_q   <= 1'b0;
      long_pend_q  <= 1'b0;
      remain_q     <= '0;
      running_q    <= 1'b0;
      status_q     <= reb_pkg::BTN_RELEASED;
    end else if (step_i) begin
      count_q      <= count_d;
      rotated_q    <= rotated_d;
      press_pend_q <= press_pend_d;
      rel_pend_q   <= rel_pend_d;
      long_pend_q  <= long_pend_d;
      remain_q     <= remain_d;
      running_q    <= running_d;
      status_q     <= status_d;
    end
  end

  // Result fields; the count is sign-extended or truncated to the port width.
  always_comb begin
    result_o.position                = reb_pkg::PosW'($signed(count_d));
    result_o.turned_clockwise        = cw;
    result_o.turned_counterclockwise = ccw;
    result_o.press_event             = pr;
    result_o.long_press_event        = lp;
    result_o.release_event           = rel;
    result_o.button_status           = status_d;
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_rotary_encoder_button_qualifier_top.sv =====
// Self-checking bench for rotary_encoder_button_qualifier_top: encoder edges,
// button debounce, long-press and release qualification. Words are predicted in
// the bench and checked field by field. Depends on reb_pkg, reb_if and the RTL.
`timescale 1ns / 1ps
module tb_rotary_encoder_button_qualifier_top;

  // Operation code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HoldOffCycles = 80;
  localparam int PhaseWords = 110;

  // One row of the directed script: either an event word or a set of timer loads.
  typedef struct {
    bit               is_config;
    reb_pkg::item_t   w;
    reb_pkg::cfg_t    loads;
    bit               known;
    reb_pkg::result_t want;
  } script_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [reb_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [reb_pkg::TimerW-1:0] cfg_wdata_i;

  reb_in_if  in_if ();
  reb_out_if out_if ();

  rotary_encoder_button_qualifier_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow state of the qualifier and its timer loads.
  logic [reb_pkg::PosW-1:0]   enc_count;
  bit                         moved_since_press;
  bit                         press_due;
  bit                         release_due;
  bit                         long_due;
  logic [reb_pkg::TimerW-1:0] ticks_left;
  bit                         timer_on;
  reb_pkg::btn_state_e        shown_state;
  reb_pkg::cfg_t              timer_cfg;

  reb_pkg::result_t queued_reports[$];
  script_row_t      script[$];

  int  mismatch_count;
  int  words_sent;
  int  words_checked;
  int  presses_seen;
  int  longs_seen;
  int  releases_seen;
  int  sender_gap_max;
  int  sink_stall_max;
  bit  hold_off_pending;
  bit  pin_level;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the status word that one event produces and advances the shadow state.
  function automatic reb_pkg::result_t qualify_event(reb_pkg::item_t w);
    reb_pkg::result_t r;
    r = '0;
    case (w.operation)
      reb_pkg::OP_A_EDGE: begin
        moved_since_press = 1'b1;
        if (!w.b_level) begin
          enc_count = enc_count + 1'b1;
          r.turned_clockwise = 1'b1;
        end else begin
          enc_count = enc_count - 1'b1;
          r.turned_counterclockwise = 1'b1;
        end
      end
      reb_pkg::OP_BUTTON: begin
        if (!w.button_level) press_due = 1'b1;
        else release_due = 1'b1;
        ticks_left = timer_cfg.debounce_ticks;
        timer_on = 1'b1;
      end
      reb_pkg::OP_TICK: begin
        if (timer_on) begin
          if (ticks_left != '0) begin
            ticks_left = ticks_left - 1'b1;
          end else begin
            // Expiry: reload, then settle long, press and release checks in turn.
            ticks_left = timer_cfg.reload_ticks;
            if (long_due) begin
              long_due = 1'b0;
              if (!w.button_level) begin
                shown_state = reb_pkg::BTN_LONG;
                r.long_press_event = 1'b1;
              end
            end
            if (press_due) begin
              press_due = 1'b0;
              if (!w.button_level) begin
                shown_state = reb_pkg::BTN_PRESSED;
                moved_since_press = 1'b0;
                r.press_event = 1'b1;
                long_due = 1'b1;
                ticks_left = timer_cfg.long_press_ticks;
              end
            end
            if (release_due) begin
              release_due = 1'b0;
              if (w.button_level && !moved_since_press) begin
                shown_state = reb_pkg::BTN_RELEASED;
                r.release_event = 1'b1;
                timer_on = 1'b0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.position = enc_count;
    r.button_status = shown_state;
    return r;
  endfunction

  // Directed rows; ev lists cw, ccw, press, long, release from left to right.
  function automatic void add_row(bit known, logic [1:0] op, logic b, logic btn,
                                  int pos, logic [4:0] ev, reb_pkg::btn_state_e st);
    script_row_t row;
    row = '{default: '0};
    row.w.operation = op;
    row.w.b_level = b;
    row.w.button_level = btn;
    row.known = known;
    row.want.position = pos;
    {row.want.turned_clockwise, row.want.turned_counterclockwise, row.want.press_event,
     row.want.long_press_event, row.want.release_event} = ev;
    row.want.button_status = st;
    script.push_back(row);
  endfunction

  function automatic void add_config(logic [15:0] deb, logic [15:0] lng, logic [15:0] rld);
    script_row_t row;
    row = '{default: '0};
    row.is_config = 1'b1;
    row.loads = '{debounce_ticks: deb, long_press_ticks: lng, reload_ticks: rld};
    script.push_back(row);
  endfunction

  function automatic logic [15:0] pick_load();
    if ($urandom_range(0, 7) == 0) return 16'hFFFF;
    return 16'($urandom_range(0, 6));
  endfunction

  // Mostly well-formed button sequences with ticks at the pin level; some bounce and noise.
  function automatic reb_pkg::item_t random_event();
    reb_pkg::item_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.b_level = 1'($urandom_range(0, 1));
    w.button_level = 1'($urandom_range(0, 1));
    if (pick < 50) begin
      w.operation = reb_pkg::OP_TICK;
      if ($urandom_range(0, 9) != 0) w.button_level = pin_level;
    end else if (pick < 68) begin
      w.operation = reb_pkg::OP_A_EDGE;
    end else if (pick < 90) begin
      pin_level = ~pin_level;
      w.operation = reb_pkg::OP_BUTTON;
      w.button_level = pin_level;
    end else if (pick < 95) begin
      w.operation = reb_pkg::OP_BUTTON;
    end else begin
      w.operation = OP_UNUSED;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("%0t: word %0d %s mismatch: got %0d, want %0d",
             $time, words_checked, what, got, want);
  endtask

  task automatic match_field(string what, longint got, longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Offers one word after a random gap; the prediction is queued when it is taken.
  task automatic offer_word(reb_pkg::item_t w, bit known, reb_pkg::result_t want);
    int gap;
    reb_pkg::result_t predicted;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= w.operation;
    in_if.b_level <= w.b_level;
    in_if.button_level <= w.button_level;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = qualify_event(w);
    queued_reports.push_back(known ? want : predicted);
    words_sent++;
  endtask

  // Stops offering and waits until every queued word is back and the pipeline is empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (queued_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_timers(logic [15:0] deb, logic [15:0] lng, logic [15:0] rld);
    settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= reb_pkg::CFG_DEBOUNCE;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    cfg_index_i <= reb_pkg::CFG_LONG;
    cfg_wdata_i <= lng;
    @(posedge clk_i);
    cfg_index_i <= reb_pkg::CFG_RELOAD;
    cfg_wdata_i <= rld;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timer_cfg = '{debounce_ticks: deb, long_press_ticks: lng, reload_ticks: rld};
  endtask

  // Result side: random stalls, one long hold-off on request, field-by-field check.
  initial begin
    int stall;
    reb_pkg::result_t want;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      if (hold_off_pending) begin
        stall = HoldOffCycles;
        hold_off_pending = 1'b0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      if (queued_reports.size() == 0) begin
        report_mismatch("unexpected word", out_if.position, 0);
      end else begin
        want = queued_reports.pop_front();
        match_field("position", $signed(out_if.position), $signed(want.position));
        match_field("turned_clockwise", out_if.turned_clockwise, want.turned_clockwise);
        match_field("turned_counterclockwise", out_if.turned_counterclockwise,
                    want.turned_counterclockwise);
        match_field("press_event", out_if.press_event, want.press_event);
        match_field("long_press_event", out_if.long_press_event, want.long_press_event);
        match_field("release_event", out_if.release_event, want.release_event);
        match_field("button_status", out_if.button_status, want.button_status);
        if (^{out_if.position, out_if.turned_clockwise, out_if.turned_counterclockwise,
              out_if.press_event, out_if.long_press_event, out_if.release_event,
              out_if.button_status} === 1'bx)
          report_mismatch("unknown bits", 0, 0);
        presses_seen += want.press_event;
        longs_seen += want.long_press_event;
        releases_seen += want.release_event;
      end
      words_checked++;
    end
  end

  // Stimulus: reset, directed script, then randomized phases under varied timer loads.
  initial begin
    reb_pkg::result_t none;
    none = '0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.operation <= reb_pkg::OP_TICK;
    in_if.b_level <= 1'b0;
    in_if.button_level <= 1'b1;
    cfg_we_i <= 1'b0;
    cfg_index_i <= reb_pkg::CFG_DEBOUNCE;
    cfg_wdata_i <= '0;
    timer_cfg = '{debounce_ticks: reb_pkg::DebounceReset,
                  long_press_ticks: reb_pkg::LongReset,
                  reload_ticks: reb_pkg::ReloadReset};
    enc_count = '0;
    moved_since_press = 1'b0;
    press_due = 1'b0;
    release_due = 1'b0;
    long_due = 1'b0;
    ticks_left = '0;
    timer_on = 1'b0;
    shown_state = reb_pkg::BTN_RELEASED;
    pin_level = 1'b1;
    sender_gap_max = 12;
    sink_stall_max = 12;
    hold_off_pending = 1'b0;

    // Counting both ways, the ignored code and a tick while stopped, at reset loads.
    add_row(1, reb_pkg::OP_A_EDGE, 0, 1, 1, 5'b10000, reb_pkg::BTN_RELEASED);
    add_row(1, reb_pkg::OP_A_EDGE, 1, 1, 0, 5'b01000, reb_pkg::BTN_RELEASED);
    add_row(1, OP_UNUSED, 1, 1, 0, 5'b00000, reb_pkg::BTN_RELEASED);
    add_row(1, reb_pkg::OP_TICK, 0, 0, 0, 5'b00000, reb_pkg::BTN_RELEASED);
    // Short timers: press, long press, clean release.
    add_config(16'd0, 16'd1, 16'd2);
    add_row(1, reb_pkg::OP_BUTTON, 0, 0, 0, 5'b00000, reb_pkg::BTN_RELEASED);
    add_row(1, reb_pkg::OP_TICK, 0, 0, 0, 5'b00100, reb_pkg::BTN_PRESSED);
    add_row(0, reb_pkg::OP_TICK, 0, 0, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(1, reb_pkg::OP_TICK, 0, 0, 0, 5'b00010, reb_pkg::BTN_LONG);
    add_row(0, reb_pkg::OP_BUTTON, 0, 1, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(1, reb_pkg::OP_TICK, 0, 1, 0, 5'b00001, reb_pkg::BTN_RELEASED);
    // Press, then rotation blocks the release; long check fails with the button up.
    add_row(0, reb_pkg::OP_BUTTON, 0, 0, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_TICK, 0, 0, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_A_EDGE, 0, 1, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_BUTTON, 1, 1, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_TICK, 1, 1, 0, '0, reb_pkg::BTN_RELEASED);
    // Press check that fails, release check that fails with the button low.
    add_row(0, reb_pkg::OP_BUTTON, 0, 0, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_TICK, 0, 1, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_BUTTON, 1, 1, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_TICK, 1, 0, 0, '0, reb_pkg::BTN_RELEASED);
    // A tick that only counts down, then press and release checks pending together.
    add_row(0, reb_pkg::OP_TICK, 0, 1, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_BUTTON, 0, 0, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_BUTTON, 0, 1, 0, '0, reb_pkg::BTN_RELEASED);
    add_row(0, reb_pkg::OP_TICK, 0, 0, 0, '0, reb_pkg::BTN_RELEASED);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_config)
        load_timers(script[i].loads.debounce_ticks, script[i].loads.long_press_ticks,
                    script[i].loads.reload_ticks);
      else
        offer_word(script[i].w, script[i].known, script[i].want);
    end

    // Random phases; each starts from an idle block with fresh timer loads.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_timers(16'h0000, 16'h0000, 16'h0000);
        1: load_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_timers(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 16'hFFFF);
        default: load_timers(pick_load(), pick_load(), pick_load());
      endcase
      sender_gap_max = (ph % 3 == 1 || ph == 4) ? 0 : 12;
      sink_stall_max = (ph % 3 == 2) ? 0 : 12;
      if (ph == 4) hold_off_pending = 1'b1;
      for (int k = 0; k < PhaseWords; k++) offer_word(random_event(), 1'b0, none);
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words and checked %0d over 12 timer settings.",
             words_sent, words_checked);
    $display("Seen: %0d presses, %0d long presses, %0d releases; final count %0d.",
             presses_seen, longs_seen, releases_seen, $signed(enc_count));
    if (mismatch_count == 0 && queued_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== rotary_encoder_button_qualifier_top.f =====
sv/reb_pkg.sv
sv/reb_if.sv
sv/reb_cfg_regs.sv
sv/reb_engine.sv
sv/rotary_encoder_button_qualifier_top.sv
tb/sv/tb_rotary_encoder_button_qualifier_top.sv
